// File: src/sjr_pkg.sv
// Shared constants, types and helper functions of the softmax row block.
// Used by sjr_div and softmax_with_jacobian_row; depends on nothing else.
package sjr_pkg;

    localparam int MAX_CLASSES = 64;
    localparam int LOGIT_BITS  = 16;
    localparam int IDX_W       = $clog2(MAX_CLASSES);
    localparam int CNT_W       = $clog2(MAX_CLASSES + 1);
    localparam int OBS_W       = 6;

    localparam int EXP_W       = 25;
    localparam int SUM_W       = 32;
    localparam int QUOT_W      = 31;
    localparam int DIV_NUM_W   = EXP_W + 30;
    localparam int DIV_CNT_W   = $clog2(DIV_NUM_W);
    localparam int MUL_W       = 32;

    localparam logic [31:0] LOG2E_Q16 = 32'd94548;
    localparam logic [31:0] LN2_Q28   = 32'd186065280;
    localparam logic [28:0] Q28_ONE   = 29'h1000_0000;
    localparam logic [30:0] Q30_ONE   = 31'h4000_0000;

    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_OBS  = 1'b1;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [SUM_W-1:0]     den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_rsp_t;

    // Reciprocal of k scaled by 2^31 and rounded up; exact floor(x / k) for x below 2^28.
    function automatic logic [31:0] recip_k(input logic [2:0] k);
        logic [31:0] r;
        begin
            case (k)
                3'd1:    r = 32'h8000_0000;
                3'd2:    r = 32'h4000_0000;
                3'd3:    r = 32'd715827883;
                3'd4:    r = 32'h2000_0000;
                3'd5:    r = 32'd429496730;
                3'd6:    r = 32'd357913942;
                default: r = 32'd0;
            endcase
            recip_k = r;
        end
    endfunction

endpackage

// File: src/sjr_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on sjr_pkg for widths and the request and response types.
module sjr_div (
    input  logic              clk,
    input  logic              rst_n,
    input  sjr_pkg::div_req_t req,
    output sjr_pkg::div_rsp_t rsp
);

    logic [sjr_pkg::DIV_NUM_W-1:0] num_reg, num_next;
    logic [sjr_pkg::SUM_W:0]       rem_reg, rem_next;
    logic [sjr_pkg::SUM_W-1:0]     den_reg, den_next;
    logic [sjr_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [sjr_pkg::SUM_W:0]       rem_sh;
    logic                          fits;

    assign rem_sh = {rem_reg[sjr_pkg::SUM_W-1:0], num_reg[sjr_pkg::DIV_NUM_W-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            rem_next = fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            num_next = {num_reg[sjr_pkg::DIV_NUM_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == sjr_pkg::DIV_CNT_W'(sjr_pkg::DIV_NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            num_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = num_reg[sjr_pkg::QUOT_W-1:0];

endmodule

// File: src/softmax_with_jacobian_row.sv
// Top level of the softmax block with optional Jacobian row output.
// Depends on sjr_pkg and sjr_div.
//
// Logits are taken one transaction per cycle until last_in; logits beyond the first 64 are
// dropped. The block then stalls its input and emits one result per stored
// logit: probabilities in mode 0, or the Jacobian row of observed_class in mode 1. Each
// exponential runs on the single shared 32x32 multiplier (range reduction and
// six Horner steps), and each normalization runs in the bit-serial divider.
// A vector of N logits is processed in order: the load, the N exponentials, in mode 1
// when observed_class is below N a setup state and a division for that class, and
// then the results. Configuration is sampled when the final logit is taken.
module softmax_with_jacobian_row (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wen,
    input  logic                                cfg_addr,
    input  logic [sjr_pkg::OBS_W-1:0]           cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [sjr_pkg::LOGIT_BITS-1:0] logit,
    input  logic                                last_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [16:0]                  value,
    output logic                                last_out
);

    typedef enum logic [17:0] {
        S_LOAD  = 18'h00001,
        S_ERD   = 18'h00002,
        S_EM1   = 18'h00004,
        S_EM2   = 18'h00008,
        S_EM3   = 18'h00010,
        S_H1    = 18'h00020,
        S_H2    = 18'h00040,
        S_H3    = 18'h00080,
        S_EXPW  = 18'h00100,
        S_QRD   = 18'h00200,
        S_QST   = 18'h00400,
        S_QWAIT = 18'h00800,
        S_PRD   = 18'h01000,
        S_PST   = 18'h02000,
        S_PWAIT = 18'h04000,
        S_PMUL  = 18'h08000,
        S_PFIN  = 18'h10000,
        S_OUT   = 18'h20000
    } state_t;

    state_t state_reg, state_next;

    logic                                  mode_cfg_reg, mode_cfg_next;
    logic [sjr_pkg::OBS_W-1:0]             obs_cfg_reg, obs_cfg_next;
    logic                                  mode_reg, mode_next;
    logic [sjr_pkg::OBS_W-1:0]             g_reg, g_next;
    logic [sjr_pkg::CNT_W-1:0]             cnt_reg, cnt_next;
    logic signed [sjr_pkg::LOGIT_BITS-1:0] max_reg, max_next;
    logic [sjr_pkg::SUM_W-1:0]             sum_reg, sum_next;
    logic [sjr_pkg::IDX_W-1:0]             j_reg, j_next;
    logic [2:0]                            k_reg, k_next;
    logic [28:0]                           a_reg, a_next;
    logic [27:0]                           r_reg, r_next;
    logic [5:0]                            n_reg, n_next;
    logic                                  big_reg, big_next;
    logic [sjr_pkg::QUOT_W-1:0]            qg_reg, qg_next;
    logic [sjr_pkg::QUOT_W-1:0]            q_reg, q_next;
    logic [63:0]                           prod_reg;
    logic                                  out_valid_reg, out_valid_next;
    logic signed [16:0]                    value_reg, value_next;
    logic                                  last_reg, last_next;

    logic signed [sjr_pkg::LOGIT_BITS-1:0] logit_mem [sjr_pkg::MAX_CLASSES];
    logic signed [sjr_pkg::LOGIT_BITS-1:0] logit_rd_reg;
    logic [sjr_pkg::EXP_W-1:0]             exps_mem [sjr_pkg::MAX_CLASSES];
    logic [sjr_pkg::EXP_W-1:0]             exps_rd_reg;
    logic [sjr_pkg::IDX_W-1:0]             exps_raddr;

    logic [sjr_pkg::MUL_W-1:0]             mul_a, mul_b;
    logic                                  in_take, store_ok, out_take, g_ok, is_last_j;
    logic signed [sjr_pkg::LOGIT_BITS:0]   diff;
    logic [6:0]                            shamt;
    logic [sjr_pkg::EXP_W-1:0]             exp_val;
    logic [63:0]                           rnd;
    logic [16:0]                           p_rnd;
    logic [16:0]                           mag;

    sjr_pkg::div_req_t div_req;
    sjr_pkg::div_rsp_t div_rsp;

    sjr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_stall  = (state_reg != S_LOAD);
    assign in_take   = in_valid && !in_stall;
    assign store_ok  = cnt_reg < sjr_pkg::CNT_W'(sjr_pkg::MAX_CLASSES);
    assign out_take  = out_valid_reg && !out_stall;
    assign g_ok      = {1'b0, g_reg} < 7'(cnt_reg);
    assign is_last_j = (sjr_pkg::CNT_W'(j_reg) + 1'b1) == cnt_reg;

    assign diff      = max_reg - logit_rd_reg;
    assign shamt     = {1'b0, n_reg} + 7'd4;
    assign exp_val   = big_reg ? '0 : sjr_pkg::EXP_W'(a_reg >> shamt);
    assign exps_raddr = (state_reg == S_QRD) ? g_reg[sjr_pkg::IDX_W-1:0] : j_reg;

    assign rnd   = prod_reg + 64'h0000_0800_0000_0000;
    assign mag   = rnd[60:44];
    assign p_rnd = 17'(({1'b0, q_reg} + 32'h0000_2000) >> 14);

    assign div_req.start = (state_reg == S_QST) || (state_reg == S_PST);
    assign div_req.num   = {exps_rd_reg, 30'd0} + sjr_pkg::DIV_NUM_W'(sum_reg >> 1);
    assign div_req.den   = sum_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_EM1:
            begin
                mul_a = 32'(diff[sjr_pkg::LOGIT_BITS-1:0]);
                mul_b = sjr_pkg::LOG2E_Q16;
            end
            S_EM2:
            begin
                mul_a = 32'(prod_reg[27:0]);
                mul_b = sjr_pkg::LN2_Q28;
            end
            S_H1:
            begin
                mul_a = 32'(r_reg);
                mul_b = 32'(a_reg);
            end
            S_H2:
            begin
                mul_a = 32'(prod_reg[55:28]);
                mul_b = sjr_pkg::recip_k(k_reg);
            end
            S_PMUL:
            begin
                mul_a = 32'(qg_reg);
                mul_b = (j_reg == g_reg[sjr_pkg::IDX_W-1:0]) ?
                        32'(sjr_pkg::Q30_ONE - qg_reg) : 32'(q_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_cfg_next  = mode_cfg_reg;
        obs_cfg_next   = obs_cfg_reg;
        mode_next      = mode_reg;
        g_next         = g_reg;
        cnt_next       = cnt_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        a_next         = a_reg;
        r_next         = r_reg;
        n_next         = n_reg;
        big_next       = big_reg;
        qg_next        = qg_reg;
        q_next         = q_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        last_next      = last_reg;

        if (cfg_wen)
        begin
            case (cfg_addr)
                sjr_pkg::CFG_MODE: mode_cfg_next = cfg_wdata[0];
                sjr_pkg::CFG_OBS:  obs_cfg_next  = cfg_wdata;
                default:           mode_cfg_next = mode_cfg_reg;
            endcase
        end

        case (state_reg)
            S_LOAD:
            begin
                if (in_take)
                begin
                    if (store_ok)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        if (cnt_reg == '0 || logit > max_reg)
                        begin
                            max_next = logit;
                        end
                    end
                    if (last_in)
                    begin
                        mode_next  = mode_cfg_reg;
                        g_next     = obs_cfg_reg;
                        sum_next   = '0;
                        j_next     = '0;
                        state_next = S_ERD;
                    end
                end
            end
            S_ERD:
            begin
                state_next = S_EM1;
            end
            S_EM1:
            begin
                state_next = S_EM2;
            end
            S_EM2:
            begin
                n_next     = prod_reg[33:28];
                big_next   = |prod_reg[63:34];
                k_next     = 3'd6;
                a_next     = sjr_pkg::Q28_ONE;
                state_next = S_EM3;
            end
            S_EM3:
            begin
                r_next     = prod_reg[55:28];
                state_next = S_H1;
            end
            S_H1:
            begin
                state_next = S_H2;
            end
            S_H2:
            begin
                state_next = S_H3;
            end
            S_H3:
            begin
                a_next = sjr_pkg::Q28_ONE - {1'b0, prod_reg[58:31]};
                k_next = k_reg - 1'b1;
                state_next = (k_reg == 3'd1) ? S_EXPW : S_H1;
            end
            S_EXPW:
            begin
                sum_next = sum_reg + sjr_pkg::SUM_W'(exp_val);
                if (is_last_j)
                begin
                    state_next = S_QRD;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_ERD;
                end
            end
            S_QRD:
            begin
                j_next = '0;
                if (mode_reg && g_ok)
                begin
                    state_next = S_QST;
                end
                else
                begin
                    qg_next    = '0;
                    state_next = S_PRD;
                end
            end
            S_QST:
            begin
                state_next = S_QWAIT;
            end
            S_QWAIT:
            begin
                if (div_rsp.done)
                begin
                    qg_next    = div_rsp.quot;
                    state_next = S_PRD;
                end
            end
            S_PRD:
            begin
                state_next = S_PST;
            end
            S_PST:
            begin
                state_next = S_PWAIT;
            end
            S_PWAIT:
            begin
                if (div_rsp.done)
                begin
                    q_next     = div_rsp.quot;
                    state_next = S_PMUL;
                end
            end
            S_PMUL:
            begin
                state_next = S_PFIN;
            end
            S_PFIN:
            begin
                if (!mode_reg)
                begin
                    value_next = (p_rnd > 17'd65535) ? 17'sd65535 : $signed(p_rnd);
                end
                else if (!g_ok)
                begin
                    value_next = '0;
                end
                else if (j_reg == g_reg[sjr_pkg::IDX_W-1:0])
                begin
                    value_next = $signed(mag);
                end
                else
                begin
                    value_next = $signed(17'(~mag + 17'd1));
                end
                last_next      = is_last_j;
                out_valid_next = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (out_take)
                begin
                    out_valid_next = 1'b0;
                    if (last_reg)
                    begin
                        cnt_next   = '0;
                        max_next   = {1'b1, {(sjr_pkg::LOGIT_BITS-1){1'b0}}};
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_PRD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            mode_cfg_reg  <= 1'b0;
            obs_cfg_reg   <= '0;
            mode_reg      <= 1'b0;
            g_reg         <= '0;
            cnt_reg       <= '0;
            max_reg       <= {1'b1, {(sjr_pkg::LOGIT_BITS-1){1'b0}}};
            sum_reg       <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_cfg_reg  <= mode_cfg_next;
            obs_cfg_reg   <= obs_cfg_next;
            mode_reg      <= mode_next;
            g_reg         <= g_next;
            cnt_reg       <= cnt_next;
            max_reg       <= max_next;
            sum_reg       <= sum_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        r_reg     <= r_next;
        n_reg     <= n_next;
        big_reg   <= big_next;
        qg_reg    <= qg_next;
        q_reg     <= q_next;
        value_reg <= value_next;
        prod_reg  <= 64'(mul_a) * 64'(mul_b);
    end

    always_ff @(posedge clk)
    begin
        if (in_take && store_ok)
        begin
            logit_mem[cnt_reg[sjr_pkg::IDX_W-1:0]] <= logit;
        end
        logit_rd_reg <= logit_mem[j_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXPW)
        begin
            exps_mem[j_reg] <= exp_val;
        end
        exps_rd_reg <= exps_mem[exps_raddr];
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign last_out  = last_reg;

    a_no_input_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && !in_stall))
        else $error("Input accepted while a result transaction is pending.");

    a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_out) |=> !in_stall)
        else $error("Input not reopened after the final result transaction.");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= sjr_pkg::CNT_W'(sjr_pkg::MAX_CLASSES))
        else $error("Stored logit count exceeds the class limit.");

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_QWAIT || state_reg == S_PWAIT))
        else $error("Divider finished outside a wait state.");

endmodule

// File: tb/softmax_row_checker.sv
// Checker for the softmax row block: watches both channels and the register port.
// Predicts each result transaction with its own fixed-point softmax model and compares.
// Depends on sjr_pkg for widths and register indexes.
`timescale 1ns / 100ps
module softmax_row_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wen,
    input  logic                                  cfg_addr,
    input  logic [sjr_pkg::OBS_W-1:0]             cfg_wdata,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic signed [sjr_pkg::LOGIT_BITS-1:0] logit,
    input  logic                                  last_in,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic signed [16:0]                    value,
    input  logic                                  last_out,
    output int                                    errors,
    output int                                    pending
);

    typedef struct packed {
        logic signed [16:0] value;
        logic               last;
    } row_entry_t;

    row_entry_t                            expected_rows[$];
    logic signed [sjr_pkg::LOGIT_BITS-1:0] held_logits[sjr_pkg::MAX_CLASSES];
    int                                    held_count;
    logic signed [sjr_pkg::LOGIT_BITS-1:0] peak_logit;
    logic                                  jacobian_mode;
    logic [sjr_pkg::OBS_W-1:0]             row_class;

    assign pending = expected_rows.size();

    function automatic longint unsigned exp_of_gap(longint unsigned gap);
        longint unsigned m, n, frac, r, a;
        m = gap * 64'd94548;
        n = m >> 28;
        frac = m & ((64'd1 << 28) - 1);
        r = (frac * 64'd186065280) >> 28;
        a = 64'd1 << 28;
        if (n >= 32)
            return 0;
        for (int k = 6; k >= 1; k--)
            a = (64'd1 << 28) - ((r * a) >> 28) / k;
        return a >> (4 + n);
    endfunction

    task automatic emit_vector();
        longint unsigned exps[sjr_pkg::MAX_CLASSES];
        longint unsigned total, q, qg, p;
        longint          v;
        row_entry_t      e;
        total = 0;
        for (int j = 0; j < held_count; j++)
        begin
            exps[j] = exp_of_gap(longint'(peak_logit) - longint'(held_logits[j]));
            total += exps[j];
        end
        qg = 0;
        if (total != 0 && row_class < held_count)
            qg = ((exps[row_class] << 30) + total / 2) / total;
        for (int j = 0; j < held_count; j++)
        begin
            q = (total != 0) ? ((exps[j] << 30) + total / 2) / total : 0;
            if (!jacobian_mode)
            begin
                p = (q + (64'd1 << 13)) >> 14;
                v = (p > 65535) ? 65535 : longint'(p);
            end
            else if (row_class >= held_count)
                v = 0;
            else if (j == row_class)
                v = longint'((qg * ((64'd1 << 30) - qg) + (64'd1 << 43)) >> 44);
            else
                v = -longint'((qg * q + (64'd1 << 43)) >> 44);
            e.value = v[16:0];
            e.last = (j + 1 == held_count);
            expected_rows.insert(expected_rows.size(), e);
        end
        held_count = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        row_entry_t e;
        if (!rst_n)
        begin
            expected_rows.delete();
            held_count = 0;
            jacobian_mode = 1'b0;
            row_class = '0;
            errors = 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                if (cfg_addr == sjr_pkg::CFG_MODE)
                    jacobian_mode = cfg_wdata[0];
                else
                    row_class = cfg_wdata;
            end
            if (in_valid && !in_stall)
            begin
                if (held_count < sjr_pkg::MAX_CLASSES)
                begin
                    held_logits[held_count] = logit;
                    if (held_count == 0 || logit > peak_logit)
                        peak_logit = logit;
                    held_count++;
                end
                if (last_in)
                    emit_vector();
            end
            if (out_valid && !out_stall)
            begin
                if (expected_rows.size() == 0)
                begin
                    $display("%0t: unexpected result transaction value=%0d last=%0b",
                             $time, value, last_out);
                    errors++;
                end
                else
                begin
                    e = expected_rows.pop_front();
                    if (e.value !== value || e.last !== last_out)
                    begin
                        $display("%0t: expected value=%0d last=%0b, actual value=%0d last=%0b",
                                 $time, e.value, e.last, value, last_out);
                        errors++;
                    end
                end
            end
        end
    end
endmodule

// File: tb/tb.sv
// Stimulus top for the softmax row block: drives vectors of logits and register settings.
// Depends on sjr_pkg, softmax_with_jacobian_row and softmax_row_checker.
`timescale 1ns / 100ps
module tb;

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  cfg_wen = 1'b0;
    logic                                  cfg_addr = sjr_pkg::CFG_MODE;
    logic [sjr_pkg::OBS_W-1:0]             cfg_wdata = '0;
    logic                                  in_valid = 1'b0;
    logic                                  in_stall;
    logic signed [sjr_pkg::LOGIT_BITS-1:0] logit = '0;
    logic                                  last_in = 1'b0;
    logic                                  out_valid;
    logic                                  out_stall = 1'b0;
    logic signed [16:0]                    value;
    logic                                  last_out;
    int                                    errors;
    int                                    pending;
    int                                    idle_cycles = 0;
    int                                    sent_logits = 0;
    bit                                    calm = 1'b0;
    bit                                    done = 1'b0;

    localparam int IDLE_LIMIT = 20000;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    softmax_with_jacobian_row DUT (.*);

    softmax_row_checker checker_i (.*);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT && !done)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    int receiver_gap = 0;
    always @(negedge clk)
    begin
        if (calm)
            out_stall <= 1'b0;
        else if (receiver_gap > 0)
        begin
            receiver_gap <= receiver_gap - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            receiver_gap <= $urandom_range(0, 7);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic write_register(input logic index, input logic [sjr_pkg::OBS_W-1:0] data);
        @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_addr <= index;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic send_logit(input logic signed [sjr_pkg::LOGIT_BITS-1:0] x,
                              input logic last);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        logit <= x;
        last_in <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        sent_logits++;
    endtask

    task automatic close_input();
        in_valid <= 1'b0;
        last_in <= 1'b0;
    endtask

    task automatic send_vector(input int len, input int spread);
        logic signed [sjr_pkg::LOGIT_BITS-1:0] x;
        for (int i = 0; i < len; i++)
        begin
            case (spread)
                0: x = $signed(sjr_pkg::LOGIT_BITS'($urandom));
                1: x = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
                default: x = $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
            endcase
            send_logit(x, i == len - 1);
        end
        close_input();
    endtask

    task automatic set_config(input logic m, input logic [sjr_pkg::OBS_W-1:0] g);
        drain();
        write_register(sjr_pkg::CFG_MODE, {{(sjr_pkg::OBS_W-1){1'b0}}, m});
        write_register(sjr_pkg::CFG_OBS, g);
    endtask

    initial
    begin
        int len;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_config(1'b0, 6'd0);
        send_logit(16'sh7FFF, 1'b1);
        send_logit(-16'sh8000, 1'b0);
        send_logit(16'sh7FFF, 1'b0);
        send_logit(16'sh0000, 1'b1);
        send_logit(16'sh1000, 1'b0);
        send_logit(16'sh1000, 1'b0);
        send_logit(-16'sh1000, 1'b1);
        close_input();
        set_config(1'b1, 6'd1);
        send_logit(16'sh0800, 1'b0);
        send_logit(-16'sh0400, 1'b0);
        send_logit(16'sh0000, 1'b1);
        close_input();
        set_config(1'b1, 6'd63);
        send_logit(16'sh0123, 1'b0);
        send_logit(16'sh0456, 1'b1);
        close_input();
        set_config(1'b0, 6'd63);
        send_vector(66, 2);

        while (sent_logits < 90)
        begin
            set_config(1'($urandom_range(0, 1)),
                       ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                   : 6'($urandom_range(0, 7)));
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
            send_vector(len, $urandom_range(0, 2));
        end

        set_config(1'b1, 6'd63);
        calm = 1'b1;
        send_vector(64, 2);
        set_config(1'b1, 6'd2);
        send_vector(5, 1);
        drain();
        done = 1'b1;
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
